>>> rtl/circular_array_sequence_defines.svh
// Assertion macros used by the circular array sequence controller.
`ifndef CIRCULAR_ARRAY_SEQUENCE_DEFINES_SVH
`define CIRCULAR_ARRAY_SEQUENCE_DEFINES_SVH

`ifndef SYNTHESIS

`define CAS_ASSERT_SAME(name, a, b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) ((a) |-> (b))) \
    else $error("assertion failed");

`define CAS_ASSERT_NEXT(name, a, b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) ((a) |=> (b))) \
    else $error("assertion failed");

`else

`define CAS_ASSERT_SAME(name, a, b)

`define CAS_ASSERT_NEXT(name, a, b)

`endif

`endif

>>> rtl/cas_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package cas_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic rd_issue;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic is_read;
    logic moves_zero;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/cas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/cas_datapath.sv
// Datapath: front pointer, count, move walker, slot RAM and result registers.
`default_nettype none

module cas_datapath #(
  parameter int CAPACITY   = cas_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cas_pkg::DATA_WIDTH_DEF,
  parameter int CW         = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cas_pkg::cmd_t         cmd_i,
  output cas_pkg::sts_t              sts_o,
  input  wire logic [1:0]            operation_i,
  input  wire logic [CW-1:0]         position_i,
  input  wire logic [DATA_WIDTH-1:0] item_value_i,
  output logic      [DATA_WIDTH-1:0] read_value_o,
  output logic      [1:0]            status_o,
  output logic      [CW-1:0]         element_count_o,
  output logic                       is_empty_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = CW + 1;

  function automatic logic [AW-1:0] inc_a(input logic [AW-1:0] a);
    if (a == AW'(CAPACITY - 1)) return '0;
    else return a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec_a(input logic [AW-1:0] a);
    if (a == '0) return AW'(CAPACITY - 1);
    else return a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_a(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
    return r[AW-1:0];
  endfunction

  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  pend_q;
  logic [AW-1:0]         pend_dst_q;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         moves_q, moves_d;
  logic                  dir_up_q;
  logic                  front_side_q;
  logic                  err_q;
  logic [1:0]            op_q;
  logic [1:0]            plan_status_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] read_value_q;
  logic [1:0]            status_q;
  logic [CW-1:0]         element_count_q;
  logic                  is_empty_q;

  logic [SW-1:0]         sum_fp, sum_fc;
  logic [CW-1:0]         half;
  logic                  front_side;
  logic [1:0]            plan_status;
  logic [CW-1:0]         plan_moves;
  logic [AW-1:0]         plan_ptr;
  logic                  plan_dir_up;
  logic [AW-1:0]         nxt_ptr;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                  is_ins_q;

  assign sum_fp     = SW'(front_q) + SW'(position_i);
  assign sum_fc     = SW'(front_q) + SW'(count_q);
  assign half       = count_q >> 1;
  assign front_side = position_i < half;
  assign is_ins_q   = (op_q == cas_pkg::OP_INSERT);

  always_comb begin
    plan_status = cas_pkg::STS_OK;
    plan_moves  = position_i;
    plan_ptr    = wrap_a(sum_fp);
    plan_dir_up = 1'b0;
    unique case (operation_i)
      cas_pkg::OP_READ: begin
        if (position_i >= count_q) plan_status = cas_pkg::STS_RANGE;
      end
      cas_pkg::OP_INSERT: begin
        if (position_i > count_q) plan_status = cas_pkg::STS_RANGE;
        else if (count_q == CW'(CAPACITY)) plan_status = cas_pkg::STS_FULL;
        if (front_side) begin
          plan_moves  = position_i;
          plan_ptr    = dec_a(front_q);
          plan_dir_up = 1'b1;
        end else begin
          plan_moves  = count_q - position_i;
          plan_ptr    = wrap_a(sum_fc);
          plan_dir_up = 1'b0;
        end
      end
      cas_pkg::OP_ERASE: begin
        if (position_i >= count_q) plan_status = cas_pkg::STS_RANGE;
        if (front_side) begin
          plan_moves  = position_i;
          plan_dir_up = 1'b0;
        end else begin
          plan_moves  = count_q - position_i - CW'(1);
          plan_dir_up = 1'b1;
        end
      end
      default: begin
        plan_status = cas_pkg::STS_RANGE;
      end
    endcase
  end

  assign nxt_ptr = dir_up_q ? inc_a(ptr_q) : dec_a(ptr_q);

  always_comb begin
    ptr_d   = ptr_q;
    moves_d = moves_q;
    if (cmd_i.load) begin
      ptr_d   = plan_ptr;
      moves_d = plan_moves;
    end else if (cmd_i.step) begin
      ptr_d   = nxt_ptr;
      moves_d = moves_q - CW'(1);
    end
  end

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.commit) begin
      if (is_ins_q) begin
        count_d = count_q + CW'(1);
        if (front_side_q) front_d = dec_a(front_q);
      end else begin
        count_d = count_q - CW'(1);
        if (front_side_q) front_d = inc_a(front_q);
      end
    end
  end

  // move reads the source now and writes it one slot over next cycle
  assign ram_re    = cmd_i.step | cmd_i.rd_issue;
  assign ram_raddr = cmd_i.step ? nxt_ptr : ptr_q;
  assign ram_we    = pend_q | (cmd_i.commit & is_ins_q);
  assign ram_waddr = pend_q ? pend_dst_q : ptr_q;
  assign ram_wdata = pend_q ? ram_rdata : val_q;

  cas_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      pend_q  <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    moves_q    <= moves_d;
    pend_dst_q <= ptr_q;
    if (cmd_i.load) begin
      op_q          <= operation_i;
      val_q         <= item_value_i;
      plan_status_q <= plan_status;
      err_q         <= (plan_status != cas_pkg::STS_OK);
      front_side_q  <= front_side;
      dir_up_q      <= plan_dir_up;
    end
    if (cmd_i.out_load) begin
      read_value_q    <= (op_q == cas_pkg::OP_READ && !err_q) ? ram_rdata : '0;
      status_q        <= plan_status_q;
      element_count_q <= count_q;
      is_empty_q      <= (count_q == '0);
    end
  end

  assign sts_o.err        = err_q;
  assign sts_o.is_read    = (op_q == cas_pkg::OP_READ);
  assign sts_o.moves_zero = (moves_q == '0);

  assign read_value_o    = read_value_q;
  assign status_o        = status_q;
  assign element_count_o = element_count_q;
  assign is_empty_o      = is_empty_q;

endmodule

`default_nettype wire

>>> rtl/cas_ctrl.sv
// Controller: sequences accept, entry moves, commit and result beat.
`default_nettype none
`include "circular_array_sequence_defines.svh"

module cas_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire cas_pkg::sts_t sts_i,
  output cas_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (sts_i.err) begin
          state_d = ST_FINISH;
        end else if (sts_i.is_read) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_FINISH;
        end else if (!sts_i.moves_zero) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `CAS_ASSERT_SAME(a_step_needs_moves, cmd_o.step, !sts_i.moves_zero)
  `CAS_ASSERT_SAME(a_commit_only_ok, cmd_o.commit, !sts_i.err && !sts_i.is_read)
  `CAS_ASSERT_NEXT(a_accept_to_move, in_valid_i && !in_stall_o, state_q == ST_MOVE)
  `CAS_ASSERT_NEXT(a_result_shown, cmd_o.out_load, out_valid_o)

endmodule

`default_nettype wire

>>> rtl/circular_array_sequence.sv
// Sequence: a read or refused beat passes idle, move and finish before out_valid rises;
// an insert or erase also steps n entries in move, then commits; n = entries moved,
// at most CAPACITY/2, one entry per cycle through the single write port of the slot RAM.
// One beat in work at a time; in_stall holds the next beat off until the result is loaded.
// Reset (async, active low) clears front pointer, count and control; slot RAM
// contents are left undefined and are never read before being written.
`default_nettype none

module circular_array_sequence #(
  parameter int CAPACITY   = cas_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cas_pkg::DATA_WIDTH_DEF,
  parameter int CW         = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            operation_i,
  input  wire logic [CW-1:0]         position_i,
  input  wire logic [DATA_WIDTH-1:0] item_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [DATA_WIDTH-1:0] read_value_o,
  output logic      [1:0]            status_o,
  output logic      [CW-1:0]         element_count_o,
  output logic                       is_empty_o
);

  cas_pkg::cmd_t cmd;
  cas_pkg::sts_t sts;

  cas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cas_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (CW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .read_value_o    (read_value_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .is_empty_o      (is_empty_o)
  );

endmodule

`default_nettype wire
